### hdl/nu2x_pkg.sv
package nu2x_pkg;

  localparam int MAX_IN_DIM   = 64;
  localparam int MAX_CH_WORDS = 64;
  localparam int WORD_BITS    = 32;

  localparam int CFG_BITS     = 7;
  localparam int CFG_IDX_BITS = 2;
  localparam int CNT_BITS     = 6;
  localparam int ADDR_BITS    = 20;
  localparam int DIM2_BITS    = CFG_BITS + 1;
  localparam int PIX_BITS     = 14;
  localparam int STRIDE_BITS  = 14;
  localparam int COPY_BITS    = 2;

  localparam logic [CFG_BITS-1:0] DIM_LIMIT = CFG_BITS'(MAX_IN_DIM);
  localparam logic [CFG_BITS-1:0] CW_LIMIT  = CFG_BITS'(MAX_CH_WORDS);
  localparam logic [CFG_BITS-1:0] CFG_ONE   = CFG_BITS'(1);

  localparam logic [CFG_IDX_BITS-1:0] REG_IMG_HEIGHT    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_WORDS = 2'd2;

  localparam logic [COPY_BITS-1:0] FIRST_COPY = 2'd0;
  localparam logic [COPY_BITS-1:0] LAST_COPY  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_BASE,
    ST_COPY
  } state_t;

  typedef struct packed {
    logic                 take;
    logic                 mul_en;
    logic                 base_en;
    logic                 load_out;
    logic [COPY_BITS-1:0] copy;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic [CFG_BITS-1:0] clamp_dim(input logic [CFG_BITS-1:0] v,
                                                    input logic [CFG_BITS-1:0] maxv);
    logic [CFG_BITS-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_ONE;
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

### hdl/nu2x_if.sv
interface nu2x_in_if;
  logic                           valid;
  logic                           ready;
  logic [nu2x_pkg::WORD_BITS-1:0] in_word;

  modport source (output valid, output in_word, input ready);
  modport sink (input valid, input in_word, output ready);
endinterface

interface nu2x_out_if;
  logic                           valid;
  logic                           ready;
  logic [nu2x_pkg::ADDR_BITS-1:0] out_addr;
  logic [nu2x_pkg::WORD_BITS-1:0] out_word;
  logic                           last_copy;
  logic                           frame_done;

  modport source (output valid, output out_addr, output out_word, output last_copy,
                  output frame_done, input ready);
  modport sink (input valid, input out_addr, input out_word, input last_copy,
                input frame_done, output ready);
endinterface

### hdl/nu2x_ctrl.sv
module nu2x_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  nu2x_pkg::sts_t   sts,
  output nu2x_pkg::cmd_t   cmd
);

  nu2x_pkg::state_t                     state, state_next;
  logic [nu2x_pkg::COPY_BITS-1:0]       copy, copy_next;
  logic                                 take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nu2x_pkg::ST_IDLE;
      copy  <= nu2x_pkg::FIRST_COPY;
    end else begin
      state <= state_next;
      copy  <= copy_next;
    end
  end

  always_comb begin
    state_next   = state;
    copy_next    = copy;
    in_ready     = 1'b0;
    cmd.mul_en   = 1'b0;
    cmd.base_en  = 1'b0;
    cmd.load_out = 1'b0;
    cmd.copy     = copy;
    unique case (state)
      nu2x_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      nu2x_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = nu2x_pkg::ST_BASE;
      end
      nu2x_pkg::ST_BASE: begin
        cmd.base_en = 1'b1;
        copy_next   = nu2x_pkg::FIRST_COPY;
        state_next  = nu2x_pkg::ST_COPY;
      end
      nu2x_pkg::ST_COPY: begin
        cmd.load_out = sts.out_free;
        in_ready     = sts.out_free && (copy == nu2x_pkg::LAST_COPY);
      end
      default: begin
        state_next = nu2x_pkg::ST_IDLE;
      end
    endcase
    take     = in_ready && in_valid;
    cmd.take = take;
    if (state == nu2x_pkg::ST_COPY && sts.out_free) begin
      if (copy == nu2x_pkg::LAST_COPY) begin
        copy_next  = nu2x_pkg::FIRST_COPY;
        state_next = take ? nu2x_pkg::ST_MUL : nu2x_pkg::ST_IDLE;
      end else begin
        copy_next = copy + 1'b1;
      end
    end else if (state == nu2x_pkg::ST_IDLE && take) begin
      state_next = nu2x_pkg::ST_MUL;
    end
  end

endmodule

### hdl/nu2x_dp.sv
module nu2x_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [nu2x_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [nu2x_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic [nu2x_pkg::WORD_BITS-1:0]      in_word,
  input  nu2x_pkg::cmd_t                      cmd,
  output nu2x_pkg::sts_t                      sts,
  nu2x_out_if.source                          out_ch
);

  logic [nu2x_pkg::CFG_BITS-1:0]    img_height, img_width, channel_words;
  logic [nu2x_pkg::CFG_BITS-1:0]    lim_h, lim_w, lim_cw;
  logic [nu2x_pkg::CNT_BITS-1:0]    row_count, col_count, word_count;
  logic [nu2x_pkg::CFG_BITS-1:0]    word_inc, col_inc, row_inc;
  logic                             last_word, last_col, last_row;

  logic [nu2x_pkg::WORD_BITS-1:0]   cur_word;
  logic [nu2x_pkg::CNT_BITS-1:0]    cur_row, cur_col, cur_wc;
  logic [nu2x_pkg::CFG_BITS-1:0]    cur_cw;
  logic [nu2x_pkg::DIM2_BITS-1:0]   cur_w2;
  logic                             cur_last;

  logic [nu2x_pkg::PIX_BITS-1:0]    row_prod;
  logic [nu2x_pkg::STRIDE_BITS-1:0] row_stride;
  logic [nu2x_pkg::ADDR_BITS-1:0]   base;

  logic [14:0]                      row_prod_full, stride_full;
  logic [nu2x_pkg::PIX_BITS-1:0]    pix;
  logic [nu2x_pkg::PIX_BITS+nu2x_pkg::CFG_BITS-1:0] base_full;
  logic [nu2x_pkg::ADDR_BITS:0]     copy_addr;
  logic                             dy, dx;
  logic                             out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_height    <= nu2x_pkg::CFG_ONE;
      img_width     <= nu2x_pkg::CFG_ONE;
      channel_words <= nu2x_pkg::CFG_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        nu2x_pkg::REG_IMG_HEIGHT:    img_height    <= cfg_data;
        nu2x_pkg::REG_IMG_WIDTH:     img_width     <= cfg_data;
        nu2x_pkg::REG_CHANNEL_WORDS: channel_words <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lim_h  = nu2x_pkg::clamp_dim(img_height, nu2x_pkg::DIM_LIMIT);
  assign lim_w  = nu2x_pkg::clamp_dim(img_width, nu2x_pkg::DIM_LIMIT);
  assign lim_cw = nu2x_pkg::clamp_dim(channel_words, nu2x_pkg::CW_LIMIT);

  assign word_inc  = {1'b0, word_count} + 1'b1;
  assign col_inc   = {1'b0, col_count} + 1'b1;
  assign row_inc   = {1'b0, row_count} + 1'b1;
  assign last_word = word_inc >= lim_cw;
  assign last_col  = last_word && (col_inc >= lim_w);
  assign last_row  = last_col && (row_inc >= lim_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= '0;
      col_count  <= '0;
      word_count <= '0;
    end else if (cmd.take) begin
      if (!last_word) begin
        word_count <= word_inc[nu2x_pkg::CNT_BITS-1:0];
      end else begin
        word_count <= '0;
        if (!last_col) begin
          col_count <= col_inc[nu2x_pkg::CNT_BITS-1:0];
        end else begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_inc[nu2x_pkg::CNT_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_word <= in_word;
      cur_row  <= row_count;
      cur_col  <= col_count;
      cur_wc   <= word_count;
      cur_cw   <= lim_cw;
      cur_w2   <= {lim_w, 1'b0};
      cur_last <= last_row;
    end
  end

  assign row_prod_full = {cur_row, 1'b0} * cur_w2;
  assign stride_full   = cur_w2 * cur_cw;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      row_prod   <= row_prod_full[nu2x_pkg::PIX_BITS-1:0];
      row_stride <= stride_full[nu2x_pkg::STRIDE_BITS-1:0];
    end
  end

  assign pix       = row_prod + nu2x_pkg::PIX_BITS'({cur_col, 1'b0});
  assign base_full = pix * cur_cw
                     + (nu2x_pkg::PIX_BITS + nu2x_pkg::CFG_BITS)'(cur_wc);

  always_ff @(posedge clk) begin
    if (cmd.base_en) begin
      base <= base_full[nu2x_pkg::ADDR_BITS-1:0];
    end
  end

  assign dy        = cmd.copy[1];
  assign dx        = cmd.copy[0];
  assign copy_addr = {1'b0, base}
                     + (dx ? (nu2x_pkg::ADDR_BITS + 1)'(cur_cw) : '0)
                     + (dy ? (nu2x_pkg::ADDR_BITS + 1)'(row_stride) : '0);

  assign sts.out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ch.out_addr   <= copy_addr[nu2x_pkg::ADDR_BITS-1:0];
      out_ch.out_word   <= cur_word;
      out_ch.last_copy  <= (cmd.copy == nu2x_pkg::LAST_COPY);
      out_ch.frame_done <= (cmd.copy == nu2x_pkg::LAST_COPY) && cur_last;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

### hdl/nearest_upsample_2x_writer_core.sv
// Order: a taken word is registered, then passes MUL and BASE before its first copy is
// loaded; the other three copies follow one a cycle while the output is taken.
// Flow: two multiply stages, then four copies through the single output register; the
// next word is accepted with the last copy.
// Reset: synchronous; clears counters and handshake state, registers return to 1.
module nearest_upsample_2x_writer_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [nu2x_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [nu2x_pkg::CFG_BITS-1:0]     cfg_data,
  nu2x_in_if.sink                           in_ch,
  nu2x_out_if.source                        out_ch
);

  nu2x_pkg::cmd_t cmd;
  nu2x_pkg::sts_t sts;
  logic           in_ready;

  assign in_ch.ready = in_ready;

  nu2x_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nu2x_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_ch.in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_ch    (out_ch)
  );

endmodule

### bench/nu2x_write_check.sv
`timescale 1ns / 100ps

module nu2x_write_check
  import nu2x_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  nu2x_in_if                      in_ch,
  nu2x_out_if                     out_ch,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [WORD_BITS-1:0] word;
    logic                 last_copy;
    logic                 frame_done;
  } copy_t;

  copy_t copies_q[$];

  logic [CFG_BITS-1:0] height_r;
  logic [CFG_BITS-1:0] width_r;
  logic [CFG_BITS-1:0] cwords_r;
  logic [CNT_BITS-1:0] row_c;
  logic [CNT_BITS-1:0] col_c;
  logic [CNT_BITS-1:0] word_c;

  function automatic int limit_of(input logic [CFG_BITS-1:0] v, input int ceiling);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > ceiling) begin
      return ceiling;
    end
    return int'(v);
  endfunction

  task automatic predict_copies(input logic [WORD_BITS-1:0] w);
    int    h;
    int    wd;
    int    cw;
    int    a;
    bit    end_word;
    bit    end_col;
    bit    end_frame;
    copy_t c;
    h         = limit_of(height_r, MAX_IN_DIM);
    wd        = limit_of(width_r, MAX_IN_DIM);
    cw        = limit_of(cwords_r, MAX_CH_WORDS);
    end_word  = (int'(word_c) + 1 >= cw);
    end_col   = end_word && (int'(col_c) + 1 >= wd);
    end_frame = end_col && (int'(row_c) + 1 >= h);
    for (int k = 0; k < 4; k++) begin
      a = ((2 * int'(row_c) + k / 2) * 2 * wd + 2 * int'(col_c) + k % 2) * cw
          + int'(word_c);
      c.addr       = ADDR_BITS'(a);
      c.word       = w;
      c.last_copy  = (k == 3);
      c.frame_done = (k == 3) && end_frame;
      copies_q.push_back(c);
    end
    if (!end_word) begin
      word_c = word_c + 1'b1;
    end else begin
      word_c = '0;
      if (!end_col) begin
        col_c = col_c + 1'b1;
      end else begin
        col_c = '0;
        row_c = end_frame ? '0 : row_c + 1'b1;
      end
    end
  endtask

  task automatic compare_copy(input copy_t got);
    copy_t want;
    if (copies_q.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("unexpected write: addr %h word %h last %b done %b",
                 got.addr, got.word, got.last_copy, got.frame_done);
      end
      return;
    end
    want = copies_q.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) begin
        $display("write mismatch: expected addr %h word %h last %b done %b",
                 want.addr, want.word, want.last_copy, want.frame_done);
        $display("                got      addr %h word %h last %b done %b",
                 got.addr, got.word, got.last_copy, got.frame_done);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      height_r = CFG_ONE;
      width_r  = CFG_ONE;
      cwords_r = CFG_ONE;
      row_c    = '0;
      col_c    = '0;
      word_c   = '0;
      errors   = 0;
      copies_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMG_HEIGHT: begin
            height_r = cfg_data;
          end
          REG_IMG_WIDTH: begin
            width_r = cfg_data;
          end
          REG_CHANNEL_WORDS: begin
            cwords_r = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_copies(in_ch.in_word);
      end
      if (out_ch.valid && out_ch.ready) begin
        compare_copy(copy_t'{out_ch.out_addr, out_ch.out_word, out_ch.last_copy,
                             out_ch.frame_done});
      end
    end
    pending <= copies_q.size();
  end

endmodule

### bench/nearest_upsample_2x_writer_core_tb.sv
`timescale 1ns / 100ps

module nearest_upsample_2x_writer_core_tb;
  import nu2x_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;

  int fail_count;
  int pending;
  int out_hold;
  bit steady_src;
  bit steady_sink;

  nu2x_in_if  in_ch ();
  nu2x_out_if out_ch ();

  nearest_upsample_2x_writer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  nu2x_write_check u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .errors    (fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("nearest_upsample_2x_writer_core_tb: done, errors");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic int eff_dim(input logic [CFG_BITS-1:0] v);
    if (v == '0) begin
      return 1;
    end
    return (int'(v) > 64) ? 64 : int'(v);
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return '0;
    end
    if (r < 20) begin
      return CFG_BITS'($urandom_range(65, 127));
    end
    if (r < 28) begin
      return CFG_BITS'(64);
    end
    return CFG_BITS'($urandom_range(1, 4));
  endfunction

  // sink side: random stalls, some long, none while steady
  always @(posedge clk) begin
    if (rst) begin
      out_hold     <= 0;
      out_ch.ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold     <= out_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (steady_sink) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
      out_hold     <= gap_len();
    end
  end

  task automatic send_word(input logic [WORD_BITS-1:0] w);
    int g;
    g = steady_src ? 0 : gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_word <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic run_words(input int n);
    repeat (n) send_word($urandom);
  endtask

  // hold the source until every copy has been written
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic configure(input logic [CFG_BITS-1:0] h, input logic [CFG_BITS-1:0] w,
                           input logic [CFG_BITS-1:0] cw);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_IMG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_CHANNEL_WORDS;
    cfg_data  <= cw;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= CFG_BITS'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [CFG_BITS-1:0] h;
    logic [CFG_BITS-1:0] w;
    logic [CFG_BITS-1:0] cw;
    int                  frame;
    int                  n;
    int                  done_items;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_IMG_HEIGHT;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.in_word = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one-pixel frames after reset
    send_word('0);
    send_word('1);
    send_word(32'hA5A5_5A5A);
    send_word(32'h5A5A_A5A5);

    // walk to the far corner: last row, then last column, then every word
    configure(CFG_BITS'(64), CFG_BITS'(1), CFG_BITS'(1));
    run_words(63);
    configure(CFG_BITS'(64), CFG_BITS'(64), CFG_BITS'(1));
    run_words(63);
    configure(CFG_BITS'(64), CFG_BITS'(64), CFG_BITS'(64));
    run_words(64);

    // out-of-range register values, then shrink limits mid-frame
    configure('0, '1, CFG_BITS'(65));
    send_word('1);
    send_word('0);
    run_words(3);
    configure(CFG_BITS'(2), CFG_BITS'(3), CFG_BITS'(2));
    run_words(4);
    configure('1, '0, CFG_BITS'(1));
    run_words(6);

    done_items = 0;
    while (done_items < 50) begin
      h  = pick_dim();
      w  = pick_dim();
      cw = pick_dim();
      if (eff_dim(h) * eff_dim(w) * eff_dim(cw) > 64) begin
        w  = CFG_BITS'(1);
        cw = CFG_BITS'($urandom_range(0, 1));
      end
      configure(h, w, cw);
      steady_src  <= ($urandom_range(0, 3) == 0);
      steady_sink <= ($urandom_range(0, 3) == 0);
      frame = eff_dim(h) * eff_dim(w) * eff_dim(cw);
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, frame + 2);
      end else begin
        n = frame * $urandom_range(1, 2);
      end
      if (n > 60 - done_items) begin
        n = 60 - done_items;
      end
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 24) == 0) begin
          drain();
        end
        send_word($urandom);
      end
      done_items += n;
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("nearest_upsample_2x_writer_core_tb: done, clean");
    end else begin
      $display("nearest_upsample_2x_writer_core_tb: done, errors");
    end
    $finish;
  end

endmodule
